// ----- rtl/dcbn_pkg.sv -----
// Shared constants, register indexes and types for the DC blocker and notch filter.
// Used by every module under rtl/; depends on nothing else.
package dcbn_pkg;

    // Field and datapath widths
    localparam int IN_W           = 12;
    localparam int OUT_W          = 16;
    localparam int COEF_W         = 16;
    localparam int DC_SHIFT_W     = 4;
    localparam int ACC_W          = 32;
    localparam int CFG_ADDR_W     = 3;
    localparam int CFG_DATA_W     = 16;

    // Fixed-point positions
    localparam int COEF_FRAC_BITS = 13;
    localparam int DC_UP_SHIFT    = 16;
    localparam int DC_DOWN_SHIFT  = 12;
    localparam int HP_W           = ACC_W - DC_DOWN_SHIFT;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_B0  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_B1  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_B2  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_A2  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_DC_SHIFT = 3'd4;

    // Reset values: the 3 dB notch set
    localparam logic signed [COEF_W-1:0]     COEF_B0_RST  = 16'sd8125;
    localparam logic signed [COEF_W-1:0]     COEF_B1_RST  = -16'sd14718;
    localparam logic signed [COEF_W-1:0]     COEF_B2_RST  = 16'sd7805;
    localparam logic signed [COEF_W-1:0]     COEF_A2_RST  = 16'sd7739;
    localparam logic        [DC_SHIFT_W-1:0] DC_SHIFT_RST = 4'd4;

    // Symmetric output limits
    localparam logic signed [ACC_W-1:0] OUT_MAX = 32'sd32767;
    localparam logic signed [ACC_W-1:0] OUT_MIN = -32'sd32767;

    typedef struct packed {
        logic signed [COEF_W-1:0]     b0;
        logic signed [COEF_W-1:0]     b1;
        logic signed [COEF_W-1:0]     b2;
        logic signed [COEF_W-1:0]     a2;
        logic        [DC_SHIFT_W-1:0] dc_shift;
    } cfg_t;

endpackage

// ----- rtl/dc_block_biquad_notch_filter_unit.sv -----
// Top level of the DC blocker and biquad notch filter.
// Depends on dcbn_pkg, dcbn_cfg_regs, dcbn_dc_stage and dcbn_notch_stage.
//
// One unsigned 12-bit converter sample in, one clamped 16-bit two's complement
// sample out per transaction, at a sustained rate of one sample per clock while
// out_ready stays high. A sample crosses two register stages: the DC blocker
// (accumulator update and high-pass register), then the notch (four parallel
// 16x32 multiplies, a sum and a Q13 shift, all combinational because the output
// history feeds straight back), whose result lands in the output register.
// The combinational notch recursion sets the clock limit. Each stage holds its
// data while stalled, so back-pressure on the output never drops or repeats a
// sample. Coefficients and the DC shift come up as the 3 dB notch set and are
// written through cfg_wr_en/cfg_addr/cfg_wdata; write them only while the
// filter holds no sample in flight.
module dc_block_biquad_notch_filter_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [dcbn_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [dcbn_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [dcbn_pkg::IN_W-1:0]             in_sample,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [dcbn_pkg::OUT_W-1:0]     out_sample
);

    dcbn_pkg::cfg_t                     cfg;
    logic                               hp_valid;
    logic                               hp_ready;
    logic signed [dcbn_pkg::HP_W-1:0]   hp_data;

    // Register bank
    dcbn_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // DC blocker stage
    dcbn_dc_stage u_dc_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .dc_shift  (cfg.dc_shift),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_sample (in_sample),
        .hp_valid  (hp_valid),
        .hp_ready  (hp_ready),
        .hp_data   (hp_data)
    );

    // Notch stage with output register
    dcbn_notch_stage u_notch_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .hp_valid   (hp_valid),
        .hp_ready   (hp_ready),
        .hp_data    (hp_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_sample (out_sample)
    );

endmodule

// ----- rtl/dcbn_cfg_regs.sv -----
// Configuration register bank: coefficients and DC blocker shift.
// Depends on dcbn_pkg.
module dcbn_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [dcbn_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [dcbn_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output dcbn_pkg::cfg_t                   cfg
);

    dcbn_pkg::cfg_t cfg_reg;
    dcbn_pkg::cfg_t cfg_next;

    // Decode the write; unknown indexes leave the bank unchanged
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_addr)
                dcbn_pkg::REG_COEF_B0:  cfg_next.b0 = cfg_wdata;
                dcbn_pkg::REG_COEF_B1:  cfg_next.b1 = cfg_wdata;
                dcbn_pkg::REG_COEF_B2:  cfg_next.b2 = cfg_wdata;
                dcbn_pkg::REG_COEF_A2:  cfg_next.a2 = cfg_wdata;
                dcbn_pkg::REG_DC_SHIFT:
                    cfg_next.dc_shift = cfg_wdata[dcbn_pkg::DC_SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.b0       <= dcbn_pkg::COEF_B0_RST;
            cfg_reg.b1       <= dcbn_pkg::COEF_B1_RST;
            cfg_reg.b2       <= dcbn_pkg::COEF_B2_RST;
            cfg_reg.a2       <= dcbn_pkg::COEF_A2_RST;
            cfg_reg.dc_shift <= dcbn_pkg::DC_SHIFT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/dcbn_dc_stage.sv -----
// First pipeline stage: DC blocker with its running accumulator and the high-pass register.
// Depends on dcbn_pkg.
module dcbn_dc_stage (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [dcbn_pkg::DC_SHIFT_W-1:0]       dc_shift,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [dcbn_pkg::IN_W-1:0]             in_sample,
    output logic                                  hp_valid,
    input  logic                                  hp_ready,
    output logic signed [dcbn_pkg::HP_W-1:0]      hp_data
);

    logic                                   hp_vld_reg;
    logic                                   hp_vld_next;
    logic signed [dcbn_pkg::HP_W-1:0]       hp_reg;
    logic signed [dcbn_pkg::ACC_W-1:0]      dc_accum_reg;
    logic signed [dcbn_pkg::ACC_W-1:0]      dc_accum_next;
    logic signed [dcbn_pkg::IN_W-1:0]       x_ctr;
    logic signed [dcbn_pkg::ACC_W-1:0]      x_up;
    logic signed [dcbn_pkg::ACC_W-1:0]      diff;
    logic signed [dcbn_pkg::ACC_W-1:0]      hp_wide;
    logic                                   accept;

    // Take a new transaction when the stage is empty or drains this cycle
    assign in_ready = !hp_vld_reg || hp_ready;
    assign accept   = in_valid && in_ready;

    // Remove the midpoint (flip the top bit), scale up, subtract the running DC estimate
    always_comb
    begin
        x_ctr         = {~in_sample[dcbn_pkg::IN_W-1], in_sample[dcbn_pkg::IN_W-2:0]};
        x_up          = dcbn_pkg::ACC_W'(x_ctr) <<< dcbn_pkg::DC_UP_SHIFT;
        diff          = x_up - dc_accum_reg;
        dc_accum_next = dc_accum_reg + (diff >>> dc_shift);
        hp_wide       = diff >>> dcbn_pkg::DC_DOWN_SHIFT;
    end

    // Hold the valid flag until the notch stage takes the sample
    always_comb
    begin
        if (accept)
            hp_vld_next = 1'b1;
        else if (hp_ready)
            hp_vld_next = 1'b0;
        else
            hp_vld_next = hp_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hp_vld_reg   <= 1'b0;
            dc_accum_reg <= '0;
        end
        else
        begin
            hp_vld_reg <= hp_vld_next;
            if (accept)
                dc_accum_reg <= dc_accum_next;
        end
    end

    // High-pass sample register
    always_ff @(posedge clk)
    begin
        if (accept)
            hp_reg <= hp_wide[dcbn_pkg::HP_W-1:0];
    end

    assign hp_valid = hp_vld_reg;
    assign hp_data  = hp_reg;

endmodule

// ----- rtl/dcbn_notch_stage.sv -----
// Second pipeline stage: Q13 biquad notch with its histories, output clamp and output register.
// Depends on dcbn_pkg.
module dcbn_notch_stage (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  dcbn_pkg::cfg_t                        cfg,
    input  logic                                  hp_valid,
    output logic                                  hp_ready,
    input  logic signed [dcbn_pkg::HP_W-1:0]      hp_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [dcbn_pkg::OUT_W-1:0]     out_sample
);

    logic                                   out_vld_reg;
    logic                                   out_vld_next;
    logic signed [dcbn_pkg::OUT_W-1:0]      out_sample_reg;
    logic signed [dcbn_pkg::HP_W-1:0]       hp_hist_one_reg;
    logic signed [dcbn_pkg::HP_W-1:0]       hp_hist_two_reg;
    logic signed [dcbn_pkg::ACC_W-1:0]      notch_hist_one_reg;
    logic signed [dcbn_pkg::ACC_W-1:0]      notch_hist_two_reg;
    logic signed [dcbn_pkg::ACC_W-1:0]      h0;
    logic signed [dcbn_pkg::ACC_W-1:0]      fb;
    logic signed [dcbn_pkg::ACC_W-1:0]      h2;
    logic signed [dcbn_pkg::ACC_W-1:0]      p0;
    logic signed [dcbn_pkg::ACC_W-1:0]      p1;
    logic signed [dcbn_pkg::ACC_W-1:0]      p2;
    logic signed [dcbn_pkg::ACC_W-1:0]      p3;
    logic signed [dcbn_pkg::ACC_W-1:0]      acc;
    logic signed [dcbn_pkg::ACC_W-1:0]      y;
    logic signed [dcbn_pkg::OUT_W-1:0]      y_clamped;
    logic                                   advance;

    // Move a sample in when the output register is empty or being taken
    assign hp_ready = !out_vld_reg || out_ready;
    assign advance  = hp_valid && hp_ready;

    // Four parallel products, all wrapping at 32 bits
    always_comb
    begin
        h0  = dcbn_pkg::ACC_W'(hp_data);
        fb  = dcbn_pkg::ACC_W'(hp_hist_one_reg) - notch_hist_one_reg;
        h2  = dcbn_pkg::ACC_W'(hp_hist_two_reg);
        p0  = h0 * dcbn_pkg::ACC_W'($signed(cfg.b0));
        p1  = fb * dcbn_pkg::ACC_W'($signed(cfg.b1));
        p2  = h2 * dcbn_pkg::ACC_W'($signed(cfg.b2));
        p3  = notch_hist_two_reg * dcbn_pkg::ACC_W'($signed(cfg.a2));
        acc = p0 + p1 + p2 - p3;
        y   = acc >>> dcbn_pkg::COEF_FRAC_BITS;
    end

    // Clamp symmetrically; the history keeps the unclamped value
    always_comb
    begin
        if (y > dcbn_pkg::OUT_MAX)
            y_clamped = dcbn_pkg::OUT_MAX[dcbn_pkg::OUT_W-1:0];
        else if (y < dcbn_pkg::OUT_MIN)
            y_clamped = dcbn_pkg::OUT_MIN[dcbn_pkg::OUT_W-1:0];
        else
            y_clamped = y[dcbn_pkg::OUT_W-1:0];
    end

    // Hold the result until the consumer takes it
    always_comb
    begin
        if (advance)
            out_vld_next = 1'b1;
        else if (out_ready)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg        <= 1'b0;
            hp_hist_one_reg    <= '0;
            hp_hist_two_reg    <= '0;
            notch_hist_one_reg <= '0;
            notch_hist_two_reg <= '0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            if (advance)
            begin
                hp_hist_two_reg    <= hp_hist_one_reg;
                hp_hist_one_reg    <= hp_data;
                notch_hist_two_reg <= notch_hist_one_reg;
                notch_hist_one_reg <= y;
            end
        end
    end

    // Output data register
    always_ff @(posedge clk)
    begin
        if (advance)
            out_sample_reg <= y_clamped;
    end

    assign out_valid  = out_vld_reg;
    assign out_sample = out_sample_reg;

endmodule
